/* rtl/gje_pkg.sv */
package gje_pkg;

  localparam int MAX_SIZE_DEF = 8;
  localparam int DW           = 32;
  localparam int FRAC         = 16;
  localparam int CFG_W        = 4;
  localparam int LC_W         = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
  localparam logic [DW-1:0]    Q_ONE     = 32'h0001_0000;
  localparam logic [DW-1:0]    Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [DW-1:0]    Q_MIN     = 32'h8000_0000;

  function automatic logic [DW-1:0] sat_prod(input logic signed [2*DW-1:0] prod);
    logic signed [2*DW-1:0] q;
    q = prod >>> FRAC;  // floor
    if (q > $signed({{DW{1'b0}}, Q_MAX})) begin
      return Q_MAX;
    end else if (q < $signed({{DW{1'b1}}, Q_MIN})) begin
      return Q_MIN;
    end
    return q[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sub_sat(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic signed [DW:0] d;
    d = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
    if (d[DW] != d[DW-1]) begin
      return d[DW] ? Q_MIN : Q_MAX;
    end
    return d[DW-1:0];
  endfunction

endpackage

/* rtl/gje_div.sv */
module gje_div import gje_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] quo
);

  localparam int NUMW = DW + FRAC;
  localparam int CW   = $clog2(NUMW);

  logic            busy_r, done_r, neg_r;
  logic [CW-1:0]   cnt_r;
  logic [DW-1:0]   rem_r, dsr_r;
  logic [NUMW-1:0] dvd_r;
  logic [DW:0]     trial;
  logic            qbit;

  assign trial = {rem_r, dvd_r[NUMW-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(NUMW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // restoring division on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DW-1] ^ den[DW-1];
      dvd_r <= {(num[DW-1] ? (~num + 1'b1) : num), {FRAC{1'b0}}};
      dsr_r <= den[DW-1] ? (~den + 1'b1) : den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? DW'(trial - {1'b0, dsr_r}) : trial[DW-1:0];
      dvd_r <= {dvd_r[NUMW-2:0], qbit};
    end
  end

  always_comb begin
    if (!neg_r) begin
      quo = (dvd_r > NUMW'(Q_MAX)) ? Q_MAX : dvd_r[DW-1:0];
    end else begin
      quo = (dvd_r > NUMW'(Q_MIN)) ? Q_MIN : (~dvd_r[DW-1:0] + 1'b1);
    end
  end

  assign done = done_r;

endmodule

/* rtl/gauss_jordan_matrix_inverse.sv */
// Gauss-Jordan inverter for a square matrix of signed Q16.16 values.
// Input channel: in_valid/in_stall carry one element per item, row-major.
// After the n*n-th element the block runs elimination without pivoting and
// emits the n*n inverse elements row-major on out_valid/out_stall, with
// out_last_result on the final one and out_singular on all of them if a
// zero pivot was met. n comes from cfg_data (4 bits) on cfg_we; 0 acts as 1
// and values above MAX_SIZE act as MAX_SIZE. Write it only while idle.
// While idle, every element offered is taken. The run is bound by one
// shared serial divider and one 32x32 multiplier; each result is read in
// S_OUT_RD and then offered in S_OUT_WT until it is taken. in_stall is
// high from the last element until the final result is taken. A stalled
// result holds its value.
// Reset (synchronous, active low) clears the load count, sets n to 8 and
// returns to idle; the matrix memory is not cleared.
module gauss_jordan_matrix_inverse import gje_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] in_element,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_inverse_element,
  output logic                 out_last_result,
  output logic                 out_singular,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_SIZE);
  localparam int NW    = $clog2(MAX_SIZE + 1);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_INIT    = 16'h0002,
    S_PIV_RD  = 16'h0004,
    S_PIV_CAP = 16'h0008,
    S_DIV_RD  = 16'h0010,
    S_DIV_M   = 16'h0020,
    S_DIV_MW  = 16'h0040,
    S_DIV_IW  = 16'h0080,
    S_ROW_RD  = 16'h0100,
    S_ROW_CAP = 16'h0200,
    S_EL_RD   = 16'h0400,
    S_EL_MUL  = 16'h0800,
    S_EL_SUB1 = 16'h1000,
    S_EL_SUB2 = 16'h2000,
    S_OUT_RD  = 16'h4000,
    S_OUT_WT  = 16'h8000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_size_r;
  logic [LC_W-1:0]   lc_r, lc_nxt, lc_inc;
  logic [NW-1:0]     n_r, n_nxt, n_eff;
  logic [RW-1:0]     p_r, p_nxt, r_r, r_nxt, c_r, c_nxt, nm1;
  logic [DW-1:0]     piv_r, piv_nxt, m_r, m_nxt;
  logic              pz_r, pz_nxt, zps_r, zps_nxt;
  logic signed [2*DW-1:0] prod_r;

  logic [DW-1:0] mat_mem [DEPTH];
  logic [DW-1:0] inv_mem [DEPTH];
  logic [DW-1:0] mat_rd_r, inv_rd_r;
  logic [DW-1:0] prow_m [MAX_SIZE];
  logic [DW-1:0] prow_i [MAX_SIZE];

  logic          mat_we, inv_we, pm_we, pi_we, mul_en;
  logic [AW-1:0] mat_wa, addr;
  logic [DW-1:0] mat_wd, inv_wd, mul_a;
  logic [RW-1:0] a_row, a_col;
  logic          c_last, r_last, p_last, run_go;

  logic          div_start, div_done, done_eff;
  logic [DW-1:0] div_num, div_q, res_m, res_i;

  gje_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (piv_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    if (cfg_size_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_size_r) > MAX_SIZE) begin
      n_eff = NW'(MAX_SIZE);
    end else begin
      n_eff = NW'(cfg_size_r);
    end
  end

  assign lc_inc = lc_r + 1'b1;
  assign run_go = (int'(lc_inc) >= int'(n_eff) * int'(n_eff));
  assign nm1    = RW'(n_r - 1'b1);
  assign c_last = (c_r == nm1);
  assign r_last = (r_r == nm1);
  assign p_last = (p_r == nm1);

  always_comb begin
    a_row = r_r;
    a_col = c_r;
    if (state_r == S_PIV_RD || state_r == S_PIV_CAP || state_r == S_DIV_RD ||
        state_r == S_DIV_M || state_r == S_DIV_MW || state_r == S_DIV_IW) begin
      a_row = p_r;
    end
    if (state_r == S_PIV_RD || state_r == S_PIV_CAP ||
        state_r == S_ROW_RD || state_r == S_ROW_CAP) begin
      a_col = p_r;
    end
  end
  assign addr = AW'(int'(a_row) * int'(n_r) + int'(a_col));

  assign done_eff = pz_r | div_done;
  assign res_m    = pz_r ? mat_rd_r : div_q;
  assign res_i    = pz_r ? inv_rd_r : div_q;
  assign div_num  = (state_r == S_DIV_M) ? mat_rd_r : inv_rd_r;
  assign div_start = (state_r == S_DIV_M) || (state_r == S_DIV_MW && done_eff);
  assign mul_a    = (state_r == S_EL_MUL) ? prow_m[c_r] : prow_i[c_r];

  always_comb begin
    state_nxt = state_r;
    lc_nxt    = lc_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    piv_nxt   = piv_r;
    pz_nxt    = pz_r;
    zps_nxt   = zps_r;
    m_nxt     = m_r;
    mat_we    = 1'b0;
    mat_wa    = addr;
    mat_wd    = res_m;
    inv_we    = 1'b0;
    inv_wd    = res_i;
    pm_we     = 1'b0;
    pi_we     = 1'b0;
    mul_en    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mat_we = 1'b1;
          mat_wa = lc_r[AW-1:0];
          mat_wd = in_element;
          if (run_go) begin
            lc_nxt    = '0;
            n_nxt     = n_eff;
            r_nxt     = '0;
            c_nxt     = '0;
            zps_nxt   = 1'b0;
            state_nxt = S_INIT;
          end else begin
            lc_nxt = lc_inc;
          end
        end
      end
      S_INIT: begin
        inv_we = 1'b1;
        inv_wd = (r_r == c_r) ? Q_ONE : '0;
        if (c_last) begin
          c_nxt = '0;
          if (r_last) begin
            r_nxt     = '0;
            p_nxt     = '0;
            state_nxt = S_PIV_RD;
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_PIV_RD: state_nxt = S_PIV_CAP;
      S_PIV_CAP: begin
        piv_nxt = mat_rd_r;
        pz_nxt  = (mat_rd_r == '0);
        if (mat_rd_r == '0) begin
          zps_nxt = 1'b1;
        end
        c_nxt     = '0;
        state_nxt = S_DIV_RD;
      end
      S_DIV_RD: state_nxt = S_DIV_M;
      S_DIV_M:  state_nxt = S_DIV_MW;
      S_DIV_MW: begin
        if (done_eff) begin
          mat_we    = 1'b1;
          pm_we     = 1'b1;
          state_nxt = S_DIV_IW;
        end
      end
      S_DIV_IW: begin
        if (done_eff) begin
          inv_we = 1'b1;
          pi_we  = 1'b1;
          if (c_last) begin
            r_nxt     = '0;
            state_nxt = S_ROW_RD;
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = S_DIV_RD;
          end
        end
      end
      S_ROW_RD: begin
        if (r_r != p_r) begin
          state_nxt = S_ROW_CAP;
        end else if (!r_last) begin
          r_nxt = r_r + 1'b1;
        end else if (p_last) begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_PIV_RD;
        end
      end
      S_ROW_CAP: begin
        m_nxt     = mat_rd_r;
        c_nxt     = '0;
        state_nxt = S_EL_RD;
      end
      S_EL_RD: state_nxt = S_EL_MUL;
      S_EL_MUL: begin
        mul_en    = 1'b1;
        state_nxt = S_EL_SUB1;
      end
      S_EL_SUB1: begin
        mat_we    = 1'b1;
        mat_wd    = sub_sat(mat_rd_r, sat_prod(prod_r));
        mul_en    = 1'b1;
        state_nxt = S_EL_SUB2;
      end
      S_EL_SUB2: begin
        inv_we = 1'b1;
        inv_wd = sub_sat(inv_rd_r, sat_prod(prod_r));
        if (!c_last) begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_EL_RD;
        end else if (!r_last) begin
          r_nxt     = r_r + 1'b1;
          state_nxt = S_ROW_RD;
        end else if (p_last) begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          p_nxt     = p_r + 1'b1;
          r_nxt     = '0;
          state_nxt = S_PIV_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_WT;
      S_OUT_WT: begin
        if (!out_stall) begin
          if (c_last && r_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OUT_RD;
            if (c_last) begin
              c_nxt = '0;
              r_nxt = r_r + 1'b1;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cfg_size_r <= CFG_RESET;
      lc_r       <= '0;
      zps_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      zps_r   <= zps_nxt;
      if (cfg_we) begin
        cfg_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    p_r   <= p_nxt;
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    piv_r <= piv_nxt;
    pz_r  <= pz_nxt;
    m_r   <= m_nxt;
    if (mul_en) begin
      prod_r <= $signed(mul_a) * $signed(m_r);
    end
    if (pm_we) begin
      prow_m[c_r] <= res_m;
    end
    if (pi_we) begin
      prow_i[c_r] <= res_i;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    mat_rd_r <= mat_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[addr] <= inv_wd;
    end
    inv_rd_r <= inv_mem[addr];
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT_WT);
  assign out_inverse_element = inv_rd_r;
  assign out_last_result     = c_last && r_last;
  assign out_singular        = zps_r;

endmodule

/* rtl/gje_chk.sv */
module gje_chk import gje_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [DW-1:0] out_inverse_element,
  input logic                 out_last_result,
  input logic                 out_singular
);

  // no item is taken while results are still going out
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while results pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse_element))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // taking the last result returns the block to idle
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_result |=> !out_valid && !in_stall)
    else $error("block not idle after last result");

  // singular flag is fixed across the results of one run
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> $stable(out_singular))
    else $error("singular flag changed within a run");

endmodule

bind gauss_jordan_matrix_inverse gje_chk u_gje_chk (.*);

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gje_pkg::*;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 singular;
  } inv_elem_t;

  class inverse_scoreboard;
    logic [CFG_W-1:0]     size_reg;
    logic signed [DW-1:0] mat [64];
    logic signed [DW-1:0] inv [64];
    int                   load_count;
    inv_elem_t            pending_q [$];
    int                   errors;
    int                   matrices;
    int                   singular_runs;
    int                   results;

    function new();
      size_reg = CFG_RESET;
      load_count = 0;
      errors = 0;
      matrices = 0;
      singular_runs = 0;
      results = 0;
      foreach (mat[i]) mat[i] = '0;
    endfunction

    function int eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_SIZE_DEF) return MAX_SIZE_DEF;
      return int'(size_reg);
    endfunction

    function logic signed [DW-1:0] sat(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return Q_MAX;
      if (v < -longint'(64'h8000_0000)) return Q_MIN;
      return v[DW-1:0];
    endfunction

    function logic signed [DW-1:0] q_div(logic signed [DW-1:0] x, logic signed [DW-1:0] d);
      longint num;
      num = longint'(x) * 65536;
      return sat(num / longint'(d));
    endfunction

    function logic signed [DW-1:0] q_mul(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat(p >>> FRAC);  // floor
    endfunction

    function logic signed [DW-1:0] q_sub(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
      return sat(longint'(a) - longint'(b));
    endfunction

    function void invert(int n);
      logic signed [DW-1:0] piv, m;
      bit zero_piv;
      inv_elem_t e;
      zero_piv = 0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          inv[r*n+c] = (r == c) ? Q_ONE : '0;
      for (int p = 0; p < n; p++) begin
        piv = mat[p*n+p];
        if (piv == 0) begin
          zero_piv = 1;  // row left undivided, elimination still runs
        end else begin
          for (int c = 0; c < n; c++) begin
            mat[p*n+c] = q_div(mat[p*n+c], piv);
            inv[p*n+c] = q_div(inv[p*n+c], piv);
          end
        end
        for (int r = 0; r < n; r++) begin
          if (r == p) continue;
          m = mat[r*n+p];
          for (int c = 0; c < n; c++) begin
            mat[r*n+c] = q_sub(mat[r*n+c], q_mul(mat[p*n+c], m));
            inv[r*n+c] = q_sub(inv[r*n+c], q_mul(inv[p*n+c], m));
          end
        end
      end
      for (int i = 0; i < n*n; i++) begin
        e.value = inv[i];
        e.last = (i == n*n-1);
        e.singular = zero_piv;
        pending_q.push_back(e);
      end
      matrices++;
      if (zero_piv) singular_runs++;
    endfunction

    function void note_element(logic signed [DW-1:0] x);
      int n;
      n = eff_size();
      mat[load_count % 64] = x;
      load_count = (load_count + 1) & 7'h7F;
      if (load_count >= n*n) begin
        load_count = 0;
        invert(n);
      end
    endfunction

    task report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
      $display("tb: mismatch at %0t on %s: got %h, want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic signed [DW-1:0] value, logic last, logic sing);
      inv_elem_t e;
      results++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected item", value, '0);
        return;
      end
      e = pending_q.pop_front();
      if (value !== e.value) report_mismatch("inverse_element", value, e.value);
      if (last !== e.last) report_mismatch("last_result", last, e.last);
      if (sing !== e.singular) report_mismatch("singular", sing, e.singular);
    endtask
  endclass

  localparam int IDLE_LIMIT = 60000;
  localparam int ITEMS_WANTED = 230;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_stall;
  logic signed [DW-1:0] in_element = '0;
  logic                 out_valid;
  logic                 out_stall = 0;
  logic signed [DW-1:0] out_inverse_element;
  logic                 out_last_result;
  logic                 out_singular;
  logic                 cfg_we = 0;
  logic [CFG_W-1:0]     cfg_data = '0;

  inverse_scoreboard sb = new();
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  big_runs = 0;
  bit  quiet = 0;

  always #5 clk = ~clk;

  gauss_jordan_matrix_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_element(in_element),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inverse_element(out_inverse_element),
    .out_last_result(out_last_result), .out_singular(out_singular),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  function int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: timeout, %0d items still expected", sb.pending_q.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int g;
    g = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_inverse_element, out_last_result, out_singular);
      @(negedge clk);
      if (g > 0) begin
        out_stall = 1;
        g--;
      end else begin
        out_stall = 0;
        g = gap_len();
      end
    end
  end

  task send_element(logic signed [DW-1:0] x);
    int g;
    @(negedge clk);
    in_valid = 1;
    in_element = x;
    do @(posedge clk); while (in_stall);
    sb.note_element(x);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task set_size(logic [CFG_W-1:0] v);
    drain();
    cfg_we = 1;
    cfg_data = v;
    @(posedge clk);
    sb.size_reg = v;
    @(negedge clk);
    cfg_we = 0;
    cfg_data = CFG_W'($urandom);
  endtask

  function logic signed [DW-1:0] pick_element(int mode, bit diag);
    case (mode)
      0: begin
        if (diag)
          return ($urandom_range(0, 1) ? 1 : -1) * ($urandom_range(4, 16) * 65536 +
                 $urandom_range(0, 65535));
        return $signed($urandom_range(0, 262143)) - 131072;
      end
      1: return $urandom;
      2: return ($signed($urandom_range(0, 6)) - 3) * 65536;
      default: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return Q_MAX;
          2: return Q_MIN;
          3: return Q_ONE;
          4: return -$signed(Q_ONE);
          default: return $urandom_range(0, 1) ? 1 : -1;
        endcase
      end
    endcase
  endfunction

  task send_matrix(int n);
    int r, mode;
    r = $urandom_range(0, 99);
    mode = (r < 60) ? 0 : (r < 75) ? 1 : (r < 90) ? 2 : 3;
    for (int i = 0; i < n*n; i++)
      send_element(pick_element(mode, (i / n) == (i % n)));
  endtask

  initial begin
    int sz, n, cnt;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // 1x1: zero, one, minus one, full scale, tiny and half values
    set_size(4'd1);
    send_element('0);
    send_element(Q_ONE);
    send_element(-$signed(Q_ONE));
    send_element(Q_MAX);
    send_element(Q_MIN);
    send_element(32'sd1);
    send_element(-32'sd1);
    send_element(32'sh0000_8000);
    // size zero behaves as one
    set_size(4'd0);
    send_element(32'sh0002_0000);
    send_element(32'shFFFF_FFFF);
    // 2x2 identity, then swap matrix with zero pivot
    set_size(4'd2);
    send_element(Q_ONE); send_element('0); send_element('0); send_element(Q_ONE);
    send_element('0); send_element(Q_ONE); send_element(Q_ONE); send_element('0);
    // oversize setting clamps to the largest matrix
    set_size(4'd15);
    send_matrix(8);
    big_runs++;

    while (items_sent < ITEMS_WANTED) begin
      cnt = $urandom_range(0, 99);
      if (cnt < 8) sz = $urandom_range(8, 15);
      else if (cnt < 80) sz = $urandom_range(1, 4);
      else if (cnt < 95) sz = $urandom_range(5, 7);
      else sz = 0;
      n = (sz == 0) ? 1 : (sz > 8) ? 8 : sz;
      if (n == 8) begin
        if (big_runs >= 2) begin
          sz = 3;
          n = 3;
        end else begin
          big_runs++;
        end
      end
      quiet = ($urandom_range(0, 3) == 0);
      set_size(sz[CFG_W-1:0]);
      cnt = (n >= 6) ? 1 : $urandom_range(1, 3);
      for (int k = 0; k < cnt; k++) begin
        send_matrix(n);
        if ($urandom_range(0, 4) == 0) drain();
      end
      quiet = 0;
    end

    drain();
    repeat (100) @(negedge clk);
    $display("tb: %0d elements in, %0d matrices (%0d singular), %0d results checked",
             items_sent, sb.matrices, sb.singular_runs, sb.results);
    $display("tb: random sizes incl. zero and oversize settings, stalls on both sides");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gje_pkg.sv
rtl/gje_div.sv
rtl/gauss_jordan_matrix_inverse.sv
rtl/gje_chk.sv
verif/tb.sv
